// File: rtl/bir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types, register codes and helpers of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int SIZE_W  = 9;
    localparam int STEP_W  = 25;
    localparam int COORD_W = 8;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    typedef logic [CHAN_W-1:0]     t_chan;
    typedef logic [PIX_W-1:0]      t_pixel;
    typedef logic [SIZE_W-1:0]     t_size;
    typedef logic [STEP_W-1:0]     t_step;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    localparam t_cfg_idx CFG_SRC_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_SRC_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_STEP_X     = 2'd2;
    localparam t_cfg_idx CFG_STEP_Y     = 2'd3;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam t_size RST_SRC_SIZE = 9'd256;
    localparam t_step RST_STEP     = 25'd65536;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    function automatic t_chan chan_sel(input t_pixel pix, input logic [1:0] ch);
        t_chan c;
        unique case (ch)
            CH_RED:   c = pix[23:16];
            CH_GREEN: c = pix[15:8];
            default:  c = pix[7:0];
        endcase
        return c;
    endfunction

endpackage

// File: rtl/bir_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_ram
// Single-port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bilinear_image_resize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Bilinear RGB scaler with an on-chip source frame store.
// ----------------------------------------------------------------------------
// A write (cmd 0) stores one source pixel; busy stays low, so writes can be
// issued every cycle. A request (cmd 1) holds busy high through two passes
// through the shared multiplier for the coordinates, a clamp state, four
// reads of the single-port frame memory plus a wait for the registered read
// data, and per color channel three multiplier passes and one accumulate
// step. The result appears on the output ports with o_strobe for exactly one
// cycle, the same cycle busy drops, so a new request is taken only once the
// result is out; the receiver cannot stall, so capture it then. The
// frame store has no reset: request only pixels that were written.
// ----------------------------------------------------------------------------
module bilinear_image_resize #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cmd,
    input  logic [bir_pkg::COORD_W-1:0]    i_coord_x,
    input  logic [bir_pkg::COORD_W-1:0]    i_coord_y,
    input  logic [bir_pkg::CHAN_W-1:0]     i_red_in,
    input  logic [bir_pkg::CHAN_W-1:0]     i_green_in,
    input  logic [bir_pkg::CHAN_W-1:0]     i_blue_in,
    output logic                           o_strobe,
    output logic [bir_pkg::CHAN_W-1:0]     o_red_out,
    output logic [bir_pkg::CHAN_W-1:0]     o_green_out,
    output logic [bir_pkg::CHAN_W-1:0]     o_blue_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;
    localparam logic [3:0] S_MY   = 4'd2;
    localparam logic [3:0] S_CY   = 4'd3;
    localparam logic [3:0] S_R00  = 4'd4;
    localparam logic [3:0] S_R10  = 4'd5;
    localparam logic [3:0] S_R01  = 4'd6;
    localparam logic [3:0] S_R11  = 4'd7;
    localparam logic [3:0] S_W11  = 4'd8;
    localparam logic [3:0] S_IT   = 4'd9;
    localparam logic [3:0] S_IB   = 4'd10;
    localparam logic [3:0] S_IV   = 4'd11;
    localparam logic [3:0] S_IA   = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic       r_strobe, n_strobe;

    bir_pkg::t_size r_src_w, r_src_h;
    bir_pkg::t_step r_step_x, r_step_y;

    logic [bir_pkg::COORD_W-1:0] r_cx, r_cy;
    logic [8:0]  r_x0, r_x1, r_y0, r_y1;
    logic [15:0] r_fx, r_fy;
    bir_pkg::t_pixel r_p00, r_p10, r_p01, r_p11;
    logic [23:0] r_top;
    logic signed [51:0] r_mul;
    bir_pkg::t_chan r_red, r_green, r_blue;

    logic signed [25:0] mul_a, mul_b;
    logic [8:0]  wm1, hm1;
    logic [16:0] ix;
    logic [8:0]  x0c, x1c, y0c, y1c;
    bir_pkg::t_chan c00, c10, c01, c11;
    logic signed [8:0]  d_top, d_bot;
    logic signed [25:0] top_full, bot_full, d_vert;
    logic signed [43:0] val;
    bir_pkg::t_chan     val_sat;
    logic [8:0]  rd_x, rd_y;
    logic [AW-1:0] rd_addr, wr_addr, ram_addr;
    logic          wr_en, accept;
    bir_pkg::t_pixel ram_rdata;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= bir_pkg::RST_SRC_SIZE;
            r_src_h  <= bir_pkg::RST_SRC_SIZE;
            r_step_x <= bir_pkg::RST_STEP;
            r_step_y <= bir_pkg::RST_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bir_pkg::CFG_SRC_WIDTH:  r_src_w  <= i_cfg_data[bir_pkg::SIZE_W-1:0];
                bir_pkg::CFG_SRC_HEIGHT: r_src_h  <= i_cfg_data[bir_pkg::SIZE_W-1:0];
                bir_pkg::CFG_STEP_X:     r_step_x <= i_cfg_data;
                bir_pkg::CFG_STEP_Y:     r_step_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last valid column and row
    always_comb begin
        if (r_src_w == '0) begin
            wm1 = '0;
        end else if (32'(r_src_w) > MAX_WIDTH) begin
            wm1 = 9'(MAX_WIDTH - 1);
        end else begin
            wm1 = r_src_w - 9'd1;
        end
        if (r_src_h == '0) begin
            hm1 = '0;
        end else if (32'(r_src_h) > MAX_HEIGHT) begin
            hm1 = 9'(MAX_HEIGHT - 1);
        end else begin
            hm1 = r_src_h - 9'd1;
        end
    end

    // edge clamp of the integer part held in r_mul
    always_comb begin
        logic [8:0] lim;
        lim = (r_state == S_MY) ? wm1 : hm1;
        ix  = r_mul[32:16];
        x0c = (ix > 17'(lim)) ? lim : ix[8:0];
        x1c = (18'(ix) + 18'd1 > 18'(lim)) ? lim : 9'(ix + 17'd1);
        y0c = x0c;
        y1c = x1c;
    end

    assign c00 = bir_pkg::chan_sel(r_p00, r_ch);
    assign c10 = bir_pkg::chan_sel(r_p10, r_ch);
    assign c01 = bir_pkg::chan_sel(r_p01, r_ch);
    assign c11 = bir_pkg::chan_sel(r_p11, r_ch);
    assign d_top = $signed({1'b0, c10}) - $signed({1'b0, c00});
    assign d_bot = $signed({1'b0, c11}) - $signed({1'b0, c01});

    assign top_full = $signed({2'b00, c00, 16'h0000}) + r_mul[25:0];
    assign bot_full = $signed({2'b00, c01, 16'h0000}) + r_mul[25:0];
    assign d_vert   = bot_full - $signed({2'b00, r_top});
    assign val      = $signed({4'h0, r_top, 16'h0000}) + r_mul[43:0];
    assign val_sat  = (val[43:40] != 4'h0) ? 8'hFF : val[39:32];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MX: begin
                mul_a = $signed({18'd0, r_cx});
                mul_b = $signed({1'b0, r_step_x});
            end
            S_MY: begin
                mul_a = $signed({18'd0, r_cy});
                mul_b = $signed({1'b0, r_step_y});
            end
            S_IT: begin
                mul_a = {{17{d_top[8]}}, d_top};
                mul_b = $signed({10'd0, r_fx});
            end
            S_IB: begin
                mul_a = {{17{d_bot[8]}}, d_bot};
                mul_b = $signed({10'd0, r_fx});
            end
            S_IV: begin
                mul_a = d_vert;
                mul_b = $signed({10'd0, r_fy});
            end
            default: ;
        endcase
    end

    always_comb begin
        rd_x = r_x0;
        rd_y = r_y0;
        unique case (r_state)
            S_R10:   rd_x = r_x1;
            S_R01:   rd_y = r_y1;
            S_R11: begin
                rd_x = r_x1;
                rd_y = r_y1;
            end
            default: ;
        endcase
    end

    assign rd_addr  = AW'(32'(rd_y) * 32'(MAX_WIDTH) + 32'(rd_x));
    assign wr_addr  = AW'(32'(i_coord_y) * 32'(MAX_WIDTH) + 32'(i_coord_x));
    assign wr_en    = accept && (i_cmd == bir_pkg::CMD_WRITE)
                      && (32'(i_coord_x) < MAX_WIDTH)
                      && (32'(i_coord_y) < MAX_HEIGHT);
    assign ram_addr = busy ? rd_addr : wr_addr;

    bir_ram #(
        .WIDTH (bir_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (ram_addr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: if (accept && i_cmd == bir_pkg::CMD_REQUEST) n_state = S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_CY;
            S_CY:   n_state = S_R00;
            S_R00:  n_state = S_R10;
            S_R10:  n_state = S_R01;
            S_R01:  n_state = S_R11;
            S_R11:  n_state = S_W11;
            S_W11: begin
                n_state = S_IT;
                n_ch    = bir_pkg::CH_RED;
            end
            S_IT:   n_state = S_IB;
            S_IB:   n_state = S_IV;
            S_IV:   n_state = S_IA;
            S_IA: begin
                if (r_ch == bir_pkg::CH_BLUE) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_state = S_IT;
                    n_ch    = r_ch + 2'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= bir_pkg::CH_RED;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= mul_a * mul_b;
        if (accept) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
        if (r_state == S_MY) begin
            r_x0 <= x0c;
            r_x1 <= x1c;
            r_fx <= r_mul[15:0];
        end
        if (r_state == S_CY) begin
            r_y0 <= y0c;
            r_y1 <= y1c;
            r_fy <= r_mul[15:0];
        end
        if (r_state == S_R10) r_p00 <= ram_rdata;
        if (r_state == S_R01) r_p10 <= ram_rdata;
        if (r_state == S_R11) r_p01 <= ram_rdata;
        if (r_state == S_W11) r_p11 <= ram_rdata;
        if (r_state == S_IB)  r_top <= top_full[23:0];
        if (r_state == S_IA) begin
            unique case (r_ch)
                bir_pkg::CH_RED:   r_red   <= val_sat;
                bir_pkg::CH_GREEN: r_green <= val_sat;
                default:           r_blue  <= val_sat;
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_IA) && $past(r_ch == bir_pkg::CH_BLUE))
        else $error("result beat without finished interpolation");

    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == bir_pkg::CMD_WRITE) |=> (!busy && !o_strobe))
        else $error("pixel write started a request");

    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == bir_pkg::CMD_REQUEST) |=> (busy && !o_strobe))
        else $error("request not taken");

endmodule

// File: tb/sv/bilinear_image_resize_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_tb
// Self-checking bench for the bilinear RGB scaler. Source pixels are loaded
// through write beats, and the bench loads every neighbour a request will
// read before it sends the request. A scoreboard keeps a shadow of the frame
// and the registers and computes each interpolated pixel in Q16/Q32 fixed
// point. Every strobed result is compared with the oldest expected pixel.
// Register settings cover zero, saturating and typical sizes and steps from
// zero to the 25-bit maximum. The sender idles at random, but for one phase.
// ----------------------------------------------------------------------------
module bilinear_image_resize_tb;

    typedef logic [bir_pkg::COORD_W-1:0] t_coord;
    typedef logic [bir_pkg::CFG_DATA_W-1:0] t_cfg_data;

    localparam int unsigned MAX_W       = 256;
    localparam int unsigned MAX_H       = 256;
    localparam int unsigned FRAME_DEPTH = MAX_W * MAX_H;
    localparam longint unsigned ONE_Q16 = 64'd65536;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          ITEM_TARGET  = 1500;
    localparam int          IDLE_PCT     = 29;
    localparam longint      TIMEOUT_NS   = 64'd20_000_000;

    class pixel_scoreboard;
        bir_pkg::t_pixel frame_shadow [FRAME_DEPTH];
        bit     written [FRAME_DEPTH];
        bir_pkg::t_size  src_width;
        bir_pkg::t_size  src_height;
        bir_pkg::t_step  step_x;
        bir_pkg::t_step  step_y;
        bir_pkg::t_pixel pending_pixels [$];
        int     mismatches;
        int     pixels_checked;

        function new();
            src_width      = bir_pkg::RST_SRC_SIZE;
            src_height     = bir_pkg::RST_SRC_SIZE;
            step_x         = bir_pkg::RST_STEP;
            step_y         = bir_pkg::RST_STEP;
            mismatches     = 0;
            pixels_checked = 0;
        endfunction

        function void write_reg(bir_pkg::t_cfg_idx idx, t_cfg_data data);
            case (idx)
                bir_pkg::CFG_SRC_WIDTH:  src_width  = data[bir_pkg::SIZE_W-1:0];
                bir_pkg::CFG_SRC_HEIGHT: src_height = data[bir_pkg::SIZE_W-1:0];
                bir_pkg::CFG_STEP_X:     step_x     = data[bir_pkg::STEP_W-1:0];
                bir_pkg::CFG_STEP_Y:     step_y     = data[bir_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        static function int unsigned eff_size(bir_pkg::t_size s, int unsigned limit);
            if (s == 0) return 1;
            if (s > limit) return limit;
            return 32'(s);
        endfunction

        // source neighbours and Q16 fractions of a destination pixel
        function void locate(input t_coord cx, input t_coord cy,
                             output int unsigned x0, output int unsigned x1,
                             output int unsigned y0, output int unsigned y1,
                             output longint unsigned fx, output longint unsigned fy);
            longint unsigned sx, sy, ix, iy;
            int unsigned w, h;
            w  = eff_size(src_width, MAX_W);
            h  = eff_size(src_height, MAX_H);
            sx = 64'(cx) * 64'(step_x);
            sy = 64'(cy) * 64'(step_y);
            ix = sx >> 16;
            iy = sy >> 16;
            fx = sx & 64'hFFFF;
            fy = sy & 64'hFFFF;
            x0 = (ix > w - 1) ? w - 1 : 32'(ix);
            x1 = (ix + 1 > w - 1) ? w - 1 : 32'(ix + 1);
            y0 = (iy > h - 1) ? h - 1 : 32'(iy);
            y1 = (iy + 1 > h - 1) ? h - 1 : 32'(iy + 1);
        endfunction

        static function bir_pkg::t_chan blend(bir_pkg::t_chan c00, bir_pkg::t_chan c10,
                                              bir_pkg::t_chan c01, bir_pkg::t_chan c11,
                                              longint unsigned fx, longint unsigned fy);
            longint unsigned top, bot, val;
            top = 64'(c00) * (ONE_Q16 - fx) + 64'(c10) * fx;
            bot = 64'(c01) * (ONE_Q16 - fx) + 64'(c11) * fx;
            val = (top * (ONE_Q16 - fy) + bot * fy) >> 32;
            return (val > 255) ? 8'hFF : val[7:0];
        endfunction

        function void note_beat(bit cmd, t_coord cx, t_coord cy,
                                bir_pkg::t_chan r, bir_pkg::t_chan g, bir_pkg::t_chan b);
            int unsigned x0, x1, y0, y1;
            longint unsigned fx, fy;
            bir_pkg::t_pixel p00, p10, p01, p11;
            if (cmd == bir_pkg::CMD_WRITE) begin
                frame_shadow[cy * MAX_W + cx] = {r, g, b};
                written[cy * MAX_W + cx]      = 1'b1;
                return;
            end
            locate(cx, cy, x0, x1, y0, y1, fx, fy);
            p00 = frame_shadow[y0 * MAX_W + x0];
            p10 = frame_shadow[y0 * MAX_W + x1];
            p01 = frame_shadow[y1 * MAX_W + x0];
            p11 = frame_shadow[y1 * MAX_W + x1];
            pending_pixels.push_back({
                blend(p00[23:16], p10[23:16], p01[23:16], p11[23:16], fx, fy),
                blend(p00[15:8],  p10[15:8],  p01[15:8],  p11[15:8],  fx, fy),
                blend(p00[7:0],   p10[7:0],   p01[7:0],   p11[7:0],   fx, fy)});
        endfunction

        function void check_pixel(bir_pkg::t_chan r, bir_pkg::t_chan g, bir_pkg::t_chan b);
            bir_pkg::t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("result strobe with no pixel outstanding: %0d %0d %0d", r, g, b);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (r !== want[23:16]) begin
                $error("red_out expected %0d actual %0d", want[23:16], r);
                mismatches++;
            end
            if (g !== want[15:8]) begin
                $error("green_out expected %0d actual %0d", want[15:8], g);
                mismatches++;
            end
            if (b !== want[7:0]) begin
                $error("blue_out expected %0d actual %0d", want[7:0], b);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      i_cmd;
    t_coord    i_coord_x;
    t_coord    i_coord_y;
    bir_pkg::t_chan    i_red_in;
    bir_pkg::t_chan    i_green_in;
    bir_pkg::t_chan    i_blue_in;
    logic      o_strobe;
    bir_pkg::t_chan    o_red_out;
    bir_pkg::t_chan    o_green_out;
    bir_pkg::t_chan    o_blue_out;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    bir_pkg::t_cfg_idx i_cfg_index;
    t_cfg_data i_cfg_data;

    pixel_scoreboard sb = new();
    int idle_pct   = IDLE_PCT;
    int n_writes   = 0;
    int n_requests = 0;
    int n_settings = 0;

    bilinear_image_resize i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_strobe    (o_strobe),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_pixel(o_red_out, o_green_out, o_blue_out);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("bilinear_image_resize_tb: errors");
        $finish;
    end

    // one beat; start stays high until the next beat or idle cycle
    task automatic drive_beat(bit cmd, t_coord cx, t_coord cy,
                              bir_pkg::t_chan r, bir_pkg::t_chan g, bir_pkg::t_chan b);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_coord_x  <= cx;
        i_coord_y  <= cy;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_beat(cmd, cx, cy, r, g, b);
        if (cmd == bir_pkg::CMD_REQUEST) n_requests++;
        else n_writes++;
    endtask

    task automatic write_pixel(t_coord cx, t_coord cy);
        drive_beat(bir_pkg::CMD_WRITE, cx, cy, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // loads any neighbour not yet written, then sends the request
    task automatic request_pixel(t_coord cx, t_coord cy);
        int unsigned xs [2];
        int unsigned ys [2];
        longint unsigned fx, fy;
        sb.locate(cx, cy, xs[0], xs[1], ys[0], ys[1], fx, fy);
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++) begin
                if (!sb.written[ys[j] * MAX_W + xs[i]]) begin
                    write_pixel(t_coord'(xs[i]), t_coord'(ys[j]));
                end
            end
        end
        drive_beat(bir_pkg::CMD_REQUEST, cx, cy,
                   8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(bir_pkg::t_cfg_idx idx, t_cfg_data data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(t_cfg_data w, t_cfg_data h, t_cfg_data sx, t_cfg_data sy);
        drain_results();
        cfg_write(bir_pkg::CFG_SRC_WIDTH, w);
        cfg_write(bir_pkg::CFG_SRC_HEIGHT, h);
        cfg_write(bir_pkg::CFG_STEP_X, sx);
        cfg_write(bir_pkg::CFG_STEP_Y, sy);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic t_cfg_data pick_size();
        t_cfg_data d;
        case ($urandom_range(9))
            0:       d = '0;
            1:       d = 25'd1;
            2:       d = 25'd256;
            3:       d = 25'($urandom_range(257, 511));
            4, 5:    d = 25'($urandom_range(2, 256));
            default: d = 25'($urandom_range(2, 24));
        endcase
        if ($urandom_range(1)) d[bir_pkg::CFG_DATA_W-1:bir_pkg::SIZE_W] = 16'($urandom);
        return d;
    endfunction

    function automatic t_cfg_data pick_step(int unsigned src);
        case ($urandom_range(9))
            0:       return '0;
            1:       return t_cfg_data'(bir_pkg::RST_STEP);
            2:       return 25'h1FFFFFF;
            3:       return 25'h1000000;
            4:       return 25'($urandom);
            5:       return 25'($urandom_range(0, 65535));
            default: return 25'((src << 16) / $urandom_range(1, 256));
        endcase
    endfunction

    initial begin
        int unsigned w_eff, h_eff, roll, phase;
        t_cfg_data   w_cfg, h_cfg;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = bir_pkg::CMD_WRITE;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bir_pkg::CFG_SRC_WIDTH;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: exact copies, corners, edge clamp
        drive_beat(bir_pkg::CMD_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        drive_beat(bir_pkg::CMD_WRITE, 8'd1, 8'd0, 8'h00, 8'h00, 8'h00);
        drive_beat(bir_pkg::CMD_WRITE, 8'd0, 8'd1, 8'h00, 8'hFF, 8'h00);
        drive_beat(bir_pkg::CMD_WRITE, 8'd1, 8'd1, 8'hAA, 8'h55, 8'hFF);
        drive_beat(bir_pkg::CMD_WRITE, 8'd255, 8'd255, 8'hFF, 8'h00, 8'hFF);
        request_pixel(8'd0, 8'd0);
        request_pixel(8'd255, 8'd255);
        request_pixel(8'd255, 8'd0);
        request_pixel(8'd0, 8'd255);
        // zero width, saturating height, largest step, half step
        configure(25'd0, {16'hFFFF, 9'd511}, 25'h1FFFFFF, 25'h8000);
        request_pixel(8'd255, 8'd255);
        request_pixel(8'd0, 8'd1);
        request_pixel(8'd3, 8'd3);
        // largest fraction, zero step
        configure(25'd256, 25'd1, 25'hFFFF, 25'd0);
        request_pixel(8'd255, 8'd7);
        request_pixel(8'd128, 8'd0);
        // tiny source, steps past the edge
        configure(25'd2, 25'd2, 25'h1000000, 25'h18000);
        request_pixel(8'd1, 8'd1);
        request_pixel(8'd0, 8'd2);

        phase = 0;
        while (n_writes + n_requests < ITEM_TARGET) begin
            phase++;
            idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            w_cfg = pick_size();
            h_cfg = pick_size();
            w_eff = pixel_scoreboard::eff_size(w_cfg[bir_pkg::SIZE_W-1:0], MAX_W);
            h_eff = pixel_scoreboard::eff_size(h_cfg[bir_pkg::SIZE_W-1:0], MAX_H);
            configure(w_cfg, h_cfg, pick_step(w_eff), pick_step(h_eff));
            repeat ((phase == 3) ? 300 : $urandom_range(40, 120)) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    if ($urandom_range(1))
                        request_pixel(8'($urandom), 8'($urandom));
                    else
                        request_pixel(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)));
                end else if (roll < 98) begin
                    if ($urandom_range(1))
                        write_pixel(8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)));
                    else
                        write_pixel(8'($urandom), 8'($urandom));
                end else begin
                    drain_results();
                end
            end
        end

        drain_results();
        $display("covered %0d pixel writes and %0d interpolated pixels (%0d checked)",
                 n_writes, n_requests, sb.pixels_checked);
        $display("over %0d register settings incl. zero/saturating sizes and extreme steps",
                 n_settings + 1);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("bilinear_image_resize_tb: clean");
        end else begin
            $display("bilinear_image_resize_tb: errors");
        end
        $finish;
    end

endmodule
